[rtl/eepd_pkg.sv]
package eepd_pkg;

    // Status codes reported with each result.
    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_SYNTAX = 2'd1;
    localparam logic [1:0] STATUS_FORMAT = 2'd2;

    // Wire types of the protobuf key byte.
    localparam logic [2:0] WT_VARINT  = 3'd0;
    localparam logic [2:0] WT_FIXED64 = 3'd1;
    localparam logic [2:0] WT_LEN     = 3'd2;
    localparam logic [2:0] WT_FIXED32 = 3'd5;

    // Field numbers with a defined meaning.
    localparam logic [4:0] FIELD_NAMESPACE = 5'd1;
    localparam logic [4:0] FIELD_CODE      = 5'd2;
    localparam logic [4:0] FIELD_MESSAGE   = 5'd3;

    // One payload byte.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } byte_req_t;

    // One decoded error record.
    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] error_code;
        logic               namespace_found;
        logic [15:0]        namespace_offset;
        logic [15:0]        namespace_length;
        logic               message_found;
        logic [15:0]        message_offset;
        logic [15:0]        message_length;
    } result_t;

endpackage

[rtl/extended_error_protobuf_decoder_unit.sv]
// The result is valid in the cycle after the last byte of a payload is accepted.
// Throughput: one payload byte per cycle while byte_stall is low; the parse state updates in a single pass per byte.
// The byte side stalls only while a finished result is held and the result side stalls.
// Reset (rst_n low, asynchronous) returns the parser to expect a key byte at offset zero
// and clears the result valid flag; the result payload register itself is not reset.
module extended_error_protobuf_decoder_unit #(
    parameter int MAX_PAYLOAD_BYTES = 65536,
    parameter int MAX_VARINT_BYTES  = 10
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_valid,
    output logic                byte_stall,
    input  eepd_pkg::byte_req_t byte_req,
    output logic                result_valid,
    input  logic                result_stall,
    output eepd_pkg::result_t   result
);

    localparam int POS_W = $clog2(MAX_PAYLOAD_BYTES + 1);
    localparam int EXT_W = (POS_W > 16) ? POS_W : 16;

    // Parser phases.
    localparam logic [2:0] PH_KEY        = 3'd0;
    localparam logic [2:0] PH_STR_LEN    = 3'd1;
    localparam logic [2:0] PH_CODE       = 3'd2;
    localparam logic [2:0] PH_SKIP_VAR   = 3'd3;
    localparam logic [2:0] PH_SKIP_LEN   = 3'd4;
    localparam logic [2:0] PH_SKIP_BYTES = 3'd5;

    logic [2:0]       phase_reg, phase_next;
    logic             is_ns_reg, is_ns_next;
    logic [63:0]      acc_reg, acc_next;
    logic [3:0]       cnt_reg, cnt_next;
    logic [POS_W-1:0] skip_reg, skip_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [1:0]       status_reg, status_next;
    logic [31:0]      code_reg, code_next;
    logic             ns_found_reg, ns_found_next;
    logic [15:0]      ns_start_reg, ns_start_next;
    logic [15:0]      ns_size_reg, ns_size_next;
    logic             msg_found_reg, msg_found_next;
    logic [15:0]      msg_start_reg, msg_start_next;
    logic [15:0]      msg_size_reg, msg_size_next;

    logic              result_valid_reg, result_valid_next;
    eepd_pkg::result_t result_reg, result_next;

    logic              accept;
    logic [4:0]        field;
    logic [2:0]        key_wt;
    logic [5:0]        shamt;
    logic [63:0]       acc_upd;
    logic [3:0]        cnt_upd;
    logic [EXT_W-1:0]  pos_ext;
    logic [15:0]       str_start;
    logic [1:0]        final_status;

    assign byte_stall   = result_valid_reg & result_stall;
    assign accept       = byte_valid & ~byte_stall;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Key decode, varint accumulation and string start offset.
    assign field     = byte_req.data_byte[7:3];
    assign key_wt    = byte_req.data_byte[2:0];
    assign shamt     = 6'(cnt_reg) * 6'd7;
    assign acc_upd   = acc_reg | ({57'd0, byte_req.data_byte[6:0]} << shamt);
    assign cnt_upd   = cnt_reg + 4'd1;
    assign pos_ext   = EXT_W'(pos_reg);
    assign str_start = 16'(pos_ext + EXT_W'(1));

    // Parse state update for one accepted byte.
    always_comb
    begin
        phase_next     = phase_reg;
        is_ns_next     = is_ns_reg;
        acc_next       = acc_reg;
        cnt_next       = cnt_reg;
        skip_next      = skip_reg;
        pos_next       = pos_reg;
        status_next    = status_reg;
        code_next      = code_reg;
        ns_found_next  = ns_found_reg;
        ns_start_next  = ns_start_reg;
        ns_size_next   = ns_size_reg;
        msg_found_next = msg_found_reg;
        msg_start_next = msg_start_reg;
        msg_size_next  = msg_size_reg;
        final_status   = eepd_pkg::STATUS_OK;

        if (accept && status_reg == eepd_pkg::STATUS_OK)
        begin
            if (pos_reg >= POS_W'(MAX_PAYLOAD_BYTES))
            begin
                status_next = eepd_pkg::STATUS_FORMAT;
            end
            else
            begin
                pos_next = pos_reg + POS_W'(1);
                unique case (phase_reg)
                    PH_KEY:
                    begin
                        if (byte_req.last_byte)
                        begin
                            status_next = eepd_pkg::STATUS_FORMAT;
                        end
                        else if (field == eepd_pkg::FIELD_NAMESPACE ||
                                 field == eepd_pkg::FIELD_MESSAGE)
                        begin
                            is_ns_next = (field == eepd_pkg::FIELD_NAMESPACE);
                            if (key_wt != eepd_pkg::WT_LEN)
                            begin
                                status_next = eepd_pkg::STATUS_SYNTAX;
                            end
                            else
                            begin
                                acc_next   = '0;
                                cnt_next   = '0;
                                phase_next = PH_STR_LEN;
                            end
                        end
                        else if (field == eepd_pkg::FIELD_CODE)
                        begin
                            if (key_wt != eepd_pkg::WT_VARINT)
                            begin
                                status_next = eepd_pkg::STATUS_SYNTAX;
                            end
                            else
                            begin
                                acc_next   = '0;
                                cnt_next   = '0;
                                phase_next = PH_CODE;
                            end
                        end
                        else if (key_wt == eepd_pkg::WT_VARINT)
                        begin
                            acc_next   = '0;
                            cnt_next   = '0;
                            phase_next = PH_SKIP_VAR;
                        end
                        else if (key_wt == eepd_pkg::WT_LEN)
                        begin
                            acc_next   = '0;
                            cnt_next   = '0;
                            phase_next = PH_SKIP_LEN;
                        end
                        else if (key_wt == eepd_pkg::WT_FIXED32)
                        begin
                            skip_next  = POS_W'(4);
                            phase_next = PH_SKIP_BYTES;
                        end
                        else if (key_wt == eepd_pkg::WT_FIXED64)
                        begin
                            skip_next  = POS_W'(8);
                            phase_next = PH_SKIP_BYTES;
                        end
                        else
                        begin
                            status_next = eepd_pkg::STATUS_FORMAT;
                        end
                    end
                    PH_SKIP_BYTES:
                    begin
                        skip_next = skip_reg - POS_W'(1);
                        if (skip_reg == POS_W'(1))
                        begin
                            phase_next = PH_KEY;
                        end
                    end
                    default:
                    begin
                        // Varint byte for a length, the code, or a skipped varint.
                        acc_next = acc_upd;
                        cnt_next = cnt_upd;
                        if (byte_req.data_byte[7])
                        begin
                            if (cnt_upd >= 4'(MAX_VARINT_BYTES))
                            begin
                                status_next = eepd_pkg::STATUS_FORMAT;
                            end
                        end
                        else if (phase_reg == PH_CODE)
                        begin
                            code_next  = acc_upd[32:1] ^ {32{acc_upd[0]}};
                            phase_next = PH_KEY;
                        end
                        else if (phase_reg == PH_STR_LEN || phase_reg == PH_SKIP_LEN)
                        begin
                            if (phase_reg == PH_STR_LEN)
                            begin
                                if (is_ns_reg)
                                begin
                                    ns_found_next = 1'b1;
                                    ns_start_next = str_start;
                                    ns_size_next  = acc_upd[15:0];
                                end
                                else
                                begin
                                    msg_found_next = 1'b1;
                                    msg_start_next = str_start;
                                    msg_size_next  = acc_upd[15:0];
                                end
                            end
                            if (acc_upd == 64'd0)
                            begin
                                phase_next = PH_KEY;
                            end
                            else if (acc_upd > 64'(MAX_PAYLOAD_BYTES))
                            begin
                                status_next = eepd_pkg::STATUS_FORMAT;
                            end
                            else
                            begin
                                skip_next  = acc_upd[POS_W-1:0];
                                phase_next = PH_SKIP_BYTES;
                            end
                        end
                        else
                        begin
                            phase_next = PH_KEY;
                        end
                    end
                endcase
            end
        end

        // An unfinished field at the end of the payload is a format error.
        final_status = status_next;
        if (status_next == eepd_pkg::STATUS_OK && phase_next != PH_KEY)
        begin
            final_status = eepd_pkg::STATUS_FORMAT;
        end
    end

    // Result register: load on the last byte, release when the sink takes it.
    always_comb
    begin
        result_valid_next = result_valid_reg & result_stall;
        result_next       = result_reg;
        if (accept && byte_req.last_byte)
        begin
            result_valid_next = 1'b1;
            result_next       = '0;
            result_next.status = final_status;
            if (final_status == eepd_pkg::STATUS_OK)
            begin
                result_next.error_code       = code_next;
                result_next.namespace_found  = ns_found_next;
                result_next.namespace_offset = ns_found_next ? ns_start_next : 16'd0;
                result_next.namespace_length = ns_found_next ? ns_size_next : 16'd0;
                result_next.message_found    = msg_found_next;
                result_next.message_offset   = msg_found_next ? msg_start_next : 16'd0;
                result_next.message_length   = msg_found_next ? msg_size_next : 16'd0;
            end
        end
    end

    // Parse state registers; the last byte returns everything to its reset values.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_KEY;
            is_ns_reg     <= 1'b0;
            acc_reg       <= '0;
            cnt_reg       <= '0;
            skip_reg      <= '0;
            pos_reg       <= '0;
            status_reg    <= eepd_pkg::STATUS_OK;
            code_reg      <= '0;
            ns_found_reg  <= 1'b0;
            ns_start_reg  <= '0;
            ns_size_reg   <= '0;
            msg_found_reg <= 1'b0;
            msg_start_reg <= '0;
            msg_size_reg  <= '0;
        end
        else if (accept && byte_req.last_byte)
        begin
            phase_reg     <= PH_KEY;
            is_ns_reg     <= 1'b0;
            acc_reg       <= '0;
            cnt_reg       <= '0;
            skip_reg      <= '0;
            pos_reg       <= '0;
            status_reg    <= eepd_pkg::STATUS_OK;
            code_reg      <= '0;
            ns_found_reg  <= 1'b0;
            ns_start_reg  <= '0;
            ns_size_reg   <= '0;
            msg_found_reg <= 1'b0;
            msg_start_reg <= '0;
            msg_size_reg  <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            is_ns_reg     <= is_ns_next;
            acc_reg       <= acc_next;
            cnt_reg       <= cnt_next;
            skip_reg      <= skip_next;
            pos_reg       <= pos_next;
            status_reg    <= status_next;
            code_reg      <= code_next;
            ns_found_reg  <= ns_found_next;
            ns_start_reg  <= ns_start_next;
            ns_size_reg   <= ns_size_next;
            msg_found_reg <= msg_found_next;
            msg_start_reg <= msg_start_next;
            msg_size_reg  <= msg_size_next;
        end
    end

    // Result valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

endmodule
